### design/pfc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types and constants for the chunked Paeth filter.
// ----------------------------------------------------------------------------
package pfc_pkg;

  localparam int PIXEL_W         = 32;
  localparam int BYTE_W          = 8;
  localparam int PIXEL_BYTES     = PIXEL_W / BYTE_W;
  localparam int MAX_CHUNK_WIDTH_DEF = 1024;
  localparam int CHANNELS_DEF    = 4;

  // configuration register widths and reset values
  localparam int CFG_WIDTH_W     = 11;
  localparam int CFG_HEIGHT_W    = 13;
  localparam int HEIGHT_LIMIT    = 4096;
  localparam int ROW_W           = 12;
  localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RST  = CFG_WIDTH_W'(64);
  localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RST = CFG_HEIGHT_W'(64);

  // APB register map
  localparam int APB_DATA_W      = 32;
  localparam int APB_ADDR_W      = 4;
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_DIR    = 2'd2;

  localparam logic DIR_FORWARD = 1'b0;
  localparam logic DIR_BACK    = 1'b1;

  typedef struct packed {
    logic [CFG_WIDTH_W-1:0]  width;
    logic [CFG_HEIGHT_W-1:0] height;
    logic                    dir;
  } cfg_t;

endpackage
`default_nettype wire

### design/pfc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfc_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module pfc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(DEPTH)-1:0]  waddr,
  input  wire [WIDTH-1:0]          wdata,
  input  wire                      re,
  input  wire [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### design/pfc_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfc_regs
// APB configuration registers: chunk width, chunk height, direction.
// ----------------------------------------------------------------------------
module pfc_regs
  import pfc_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   psel,
  input  wire                   penable,
  input  wire                   pwrite,
  input  wire [APB_ADDR_W-1:0]  paddr,
  input  wire [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;
  assign idx    = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width  <= WIDTH_RST;
      cfg.height <= HEIGHT_RST;
      cfg.dir    <= DIR_FORWARD;
    end else if (wr) begin
      case (idx)
        REG_WIDTH:  cfg.width  <= pwdata[CFG_WIDTH_W-1:0];
        REG_HEIGHT: cfg.height <= pwdata[CFG_HEIGHT_W-1:0];
        REG_DIR:    cfg.dir    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_WIDTH:  prdata = APB_DATA_W'(cfg.width);
      REG_HEIGHT: prdata = APB_DATA_W'(cfg.height);
      REG_DIR:    prdata = APB_DATA_W'(cfg.dir);
      default:    prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

### design/pfc_paeth.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfc_paeth
// Per-channel Paeth predictor with modulo-256 subtract or add.
// ----------------------------------------------------------------------------
module pfc_paeth
  import pfc_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  wire [PIXEL_W-1:0]  pixel,
  input  wire [PIXEL_W-1:0]  left,
  input  wire [PIXEL_W-1:0]  up,
  input  wire [PIXEL_W-1:0]  upleft,
  input  wire                dir,
  input  wire                apply,
  output logic [PIXEL_W-1:0] result
);

  function automatic logic [BYTE_W-1:0] predict(
    input logic [BYTE_W-1:0] a,
    input logic [BYTE_W-1:0] b,
    input logic [BYTE_W-1:0] c
  );
    logic signed [BYTE_W+2:0] sa, sb, sc, da, db, dc, pa, pb, pc;
    logic [BYTE_W-1:0]        pr;
    sa = $signed({3'b000, a});
    sb = $signed({3'b000, b});
    sc = $signed({3'b000, c});
    // p - a = b - c, p - b = a - c, p - c = a + b - 2c
    da = sb - sc;
    db = sa - sc;
    dc = sa + sb - sc - sc;
    pa = (da < 0) ? -da : da;
    pb = (db < 0) ? -db : db;
    pc = (dc < 0) ? -dc : dc;
    if (pa <= pb && pa <= pc) begin
      pr = a;
    end else if (pb <= pc) begin
      pr = b;
    end else begin
      pr = c;
    end
    return pr;
  endfunction

  for (genvar ch = 0; ch < PIXEL_BYTES; ch++) begin : g_ch
    logic [BYTE_W-1:0] v, pr;
    assign v  = pixel[ch*BYTE_W +: BYTE_W];
    assign pr = predict(left[ch*BYTE_W +: BYTE_W], up[ch*BYTE_W +: BYTE_W],
                        upleft[ch*BYTE_W +: BYTE_W]);
    assign result[ch*BYTE_W +: BYTE_W] = (apply && ch < CHANNELS) ?
                                         ((dir == DIR_BACK) ? v + pr : v - pr) : v;
  end

endmodule
`default_nettype wire

### design/paeth_filter_chunked.sv
`default_nettype none
// ----------------------------------------------------------------------------
// paeth_filter_chunked
// Chunked PNG Paeth filter / reconstructor, one 32-bit pixel per request.
// ----------------------------------------------------------------------------
// Stages: stage 1 (line store read in flight), then the output register.
// Throughput: one pixel per cycle unless out_ready stalls; the line store has
//   a read port at accept and a write port at commit; same-slot overlap forwarded.
// Reset: counters, neighbor registers and output valid cleared, config regs to
//   64x64 forward; the line store is not cleared, no clearing pass is needed.
// ----------------------------------------------------------------------------
module paeth_filter_chunked
  import pfc_pkg::*;
#(
  parameter int MAX_CHUNK_WIDTH = MAX_CHUNK_WIDTH_DEF,
  parameter int CHANNELS        = CHANNELS_DEF
) (
  input  wire                   clk,
  input  wire                   rst,
  // APB config
  input  wire                   psel,
  input  wire                   penable,
  input  wire                   pwrite,
  input  wire [APB_ADDR_W-1:0]  paddr,
  input  wire [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // pixel input
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire [PIXEL_W-1:0]     pixel_in,
  // pixel output
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic [PIXEL_W-1:0]    pixel_out,
  output logic                  chunk_end
);

  localparam int XW = $clog2(MAX_CHUNK_WIDTH);
  localparam int WW = (XW + 1 > CFG_WIDTH_W) ? XW + 1 : CFG_WIDTH_W;
  localparam int HW = CFG_HEIGHT_W;

  cfg_t cfg;

  pfc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // effective chunk size, zero -> 1, saturated to the limits
  logic [WW-1:0] w_raw, w_eff;
  logic [HW-1:0] h_eff;
  assign w_raw = WW'(cfg.width);
  always_comb begin
    if (w_raw == '0) begin
      w_eff = WW'(1);
    end else if (w_raw > WW'(MAX_CHUNK_WIDTH)) begin
      w_eff = WW'(MAX_CHUNK_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    if (cfg.height == '0) begin
      h_eff = HW'(1);
    end else if (cfg.height > HW'(HEIGHT_LIMIT)) begin
      h_eff = HW'(HEIGHT_LIMIT);
    end else begin
      h_eff = cfg.height;
    end
  end

  // position counters
  logic [XW-1:0]    col;
  logic [ROW_W-1:0] row;
  logic             row_done, chunk_done;
  assign row_done   = (WW'(col) + WW'(1)) >= w_eff;
  assign chunk_done = row_done && ((HW'(row) + HW'(1)) >= h_eff);

  // stage 1: line store read in flight
  logic               s1_valid;
  logic [PIXEL_W-1:0] s1_pixel;
  logic [XW-1:0]      s1_slot;
  logic               s1_has_up;
  logic               s1_apply;
  logic               s1_last;
  logic               s1_fwd;

  logic accept, advance;
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (row_done) begin
        col <= '0;
        row <= chunk_done ? '0 : row + ROW_W'(1);
      end else begin
        col <= col + XW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel  <= pixel_in;
      s1_slot   <= col;
      s1_has_up <= (row != '0);
      s1_apply  <= (row != '0) && (col != '0);
      s1_last   <= chunk_done;
      // previous pixel commits to the same slot at this edge: RAM gives old data
      s1_fwd    <= s1_valid && (s1_slot == col);
    end
  end

  // line store
  logic [PIXEL_W-1:0] ram_rdata;
  logic [PIXEL_W-1:0] left_pixel, upper_left_pixel;
  logic [PIXEL_W-1:0] up, result, basis;

  pfc_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (MAX_CHUNK_WIDTH)
  ) u_row_store (
    .clk   (clk),
    .we    (advance),
    .waddr (s1_slot),
    .wdata (basis),
    .re    (accept),
    .raddr (col),
    .rdata (ram_rdata)
  );

  // left_pixel always holds the last committed basis, i.e. the forwarded word
  always_comb begin
    if (!s1_has_up) begin
      up = '0;
    end else if (s1_fwd) begin
      up = left_pixel;
    end else begin
      up = ram_rdata;
    end
  end

  pfc_paeth #(
    .CHANNELS (CHANNELS)
  ) u_paeth (
    .pixel  (s1_pixel),
    .left   (left_pixel),
    .up     (up),
    .upleft (upper_left_pixel),
    .dir    (cfg.dir),
    .apply  (s1_apply),
    .result (result)
  );

  assign basis = (cfg.dir == DIR_BACK) ? result : s1_pixel;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_pixel       <= '0;
      upper_left_pixel <= '0;
    end else if (advance) begin
      left_pixel       <= basis;
      upper_left_pixel <= up;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pixel_out <= result;
      chunk_end <= s1_last;
    end
  end

endmodule
`default_nettype wire

### test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives pixel chunks through the chunked Paeth filter and checks every
// result against a predictor that tracks the line store and neighbors.
// Registers are set over APB, between chunks and mid-chunk, and read back.
// ----------------------------------------------------------------------------
module testbench
  import pfc_pkg::*;
();

  localparam int MAX_W        = MAX_CHUNK_WIDTH_DEF;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PIXEL_TARGET = 1950;
  localparam int BIG_TAIL     = 40;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               is_last;
  } pixel_result_t;

  typedef struct packed {
    logic               is_reg;
    logic [1:0]         reg_idx;
    logic [31:0]        value;
    logic               typed;
    logic [PIXEL_W-1:0] exp_pixel;
    logic               exp_last;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [PIXEL_W-1:0]    pixel_in = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [PIXEL_W-1:0]    pixel_out;
  logic                  chunk_end;

  paeth_filter_chunked dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pixel_in  (pixel_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pixel_out (pixel_out),
    .chunk_end (chunk_end)
  );

  always #2 clk = ~clk;

  // predictor state
  cfg_t               model_cfg;
  logic [PIXEL_W-1:0] line_store [MAX_W];
  logic [PIXEL_W-1:0] left_px;
  logic [PIXEL_W-1:0] upleft_px;
  int                 col_cnt;
  int                 row_cnt;

  pixel_result_t expected_pixels [$];
  stim_row_t     directed_rows [$];

  // typed expectation for the directed rows that can be read off directly
  logic               typed_on = 1'b0;
  logic [PIXEL_W-1:0] typed_px;
  logic               typed_last;

  int errors = 0;
  int cycles = 0;
  int pixels_accepted = 0;
  int results_checked = 0;
  int chunks_predicted = 0;
  int reg_writes = 0;
  int in_idle_pct = 28;
  int out_idle_pct = 53;
  logic [PIXEL_W-1:0] last_pixel = '0;

  function automatic int eff_width();
    int w;
    w = model_cfg.width;
    if (w == 0) w = 1;
    if (w > MAX_W) w = MAX_W;
    return w;
  endfunction

  function automatic int eff_height();
    int h;
    h = model_cfg.height;
    if (h == 0) h = 1;
    if (h > HEIGHT_LIMIT) h = HEIGHT_LIMIT;
    return h;
  endfunction

  function automatic logic [7:0] paeth_pick(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    int ia, ib, ic, p, pa, pb, pc;
    ia = a;
    ib = b;
    ic = c;
    p = ia + ib - ic;
    pa = (p > ia) ? p - ia : ia - p;
    pb = (p > ib) ? p - ib : ib - p;
    pc = (p > ic) ? p - ic : ic - p;
    if (pa <= pb && pa <= pc) return a;
    if (pb <= pc) return b;
    return c;
  endfunction

  task automatic predict_pixel(input logic [PIXEL_W-1:0] px, output pixel_result_t r);
    int w, h, slot;
    logic [PIXEL_W-1:0] up, res;
    logic [7:0] pred, v;
    w = eff_width();
    h = eff_height();
    slot = (col_cnt < MAX_W) ? col_cnt : MAX_W - 1;
    up = (row_cnt > 0) ? line_store[slot] : '0;
    res = px;
    if (col_cnt > 0 && row_cnt > 0) begin
      for (int ch = 0; ch < CHANNELS_DEF; ch++) begin
        pred = paeth_pick(left_px[ch*8 +: 8], up[ch*8 +: 8], upleft_px[ch*8 +: 8]);
        v = px[ch*8 +: 8];
        res[ch*8 +: 8] = (model_cfg.dir == DIR_BACK) ? v + pred : v - pred;
      end
    end
    // neighbors keep the form of the mode in effect for their own pixel
    upleft_px = up;
    left_px = (model_cfg.dir == DIR_BACK) ? res : px;
    line_store[slot] = left_px;
    r.pixel = res;
    r.is_last = 1'b0;
    if (col_cnt + 1 >= w) begin
      col_cnt = 0;
      if (row_cnt + 1 >= h) begin
        row_cnt = 0;
        r.is_last = 1'b1;
        chunks_predicted++;
      end else begin
        row_cnt++;
      end
    end else begin
      col_cnt++;
    end
  endtask

  function automatic logic [31:0] reg_value(logic [1:0] idx);
    case (idx)
      REG_WIDTH:  return 32'(model_cfg.width);
      REG_HEIGHT: return 32'(model_cfg.height);
      default:    return 32'(model_cfg.dir);
    endcase
  endfunction

  function automatic stim_row_t stim_reg(logic [1:0] idx, logic [31:0] value);
    return '{1'b1, idx, value, 1'b0, '0, 1'b0};
  endfunction

  function automatic stim_row_t stim_px(logic [31:0] value);
    return '{1'b0, REG_WIDTH, value, 1'b0, '0, 1'b0};
  endfunction

  // first row or first column: the pixel must come back unchanged
  function automatic stim_row_t stim_pass(logic [31:0] value, logic is_last);
    return '{1'b0, REG_WIDTH, value, 1'b1, value, is_last};
  endfunction

  function automatic logic [PIXEL_W-1:0] random_pixel(logic [PIXEL_W-1:0] near);
    logic [PIXEL_W-1:0] px;
    for (int ch = 0; ch < 4; ch++) begin
      case ($urandom_range(3))
        0: case ($urandom_range(3))
             0: px[ch*8 +: 8] = 8'h00;
             1: px[ch*8 +: 8] = 8'hFF;
             2: px[ch*8 +: 8] = 8'h01;
             default: px[ch*8 +: 8] = 8'hFE;
           endcase
        1: px[ch*8 +: 8] = near[ch*8 +: 8] + 8'($urandom_range(6)) - 8'd3;
        default: px[ch*8 +: 8] = 8'($urandom_range(255));
      endcase
    end
    return px;
  endfunction

  task automatic note_error(string field, logic [31:0] want, logic [31:0] got);
    errors++;
    if (errors <= 10)
      $display("mismatch %s at cycle %0d: expected %h, got %h", field, cycles, want, got);
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_pixel(input logic [PIXEL_W-1:0] px);
    if (pixels_accepted < PIXEL_TARGET / 3) begin
      in_idle_pct = 28;
      out_idle_pct = 53;
    end else if (pixels_accepted < 2 * PIXEL_TARGET / 3) begin
      in_idle_pct = 53;
      out_idle_pct = 28;
    end else begin
      in_idle_pct = 0;
      out_idle_pct = 0;
    end
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    pixel_in <= px;
    last_pixel = px;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // sender holds off until every outstanding result is back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_pixels.size() != 0);
  endtask

  task automatic check_reg(input logic [1:0] idx);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== reg_value(idx)) note_error("register readback", reg_value(idx), prdata);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    // bus returns to idle before the next transfer
    @(negedge clk);
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_WIDTH:  model_cfg.width = value[CFG_WIDTH_W-1:0];
      REG_HEIGHT: model_cfg.height = value[CFG_HEIGHT_W-1:0];
      default:    model_cfg.dir = value[0];
    endcase
    reg_writes++;
    @(negedge clk);
    check_reg(idx);
  endtask

  // request accepted: predict its result
  always @(posedge clk) begin : accept_mon
    pixel_result_t r;
    if (!rst && in_valid && in_ready) begin
      predict_pixel(pixel_in, r);
      if (typed_on) begin
        r.pixel = typed_px;
        r.is_last = typed_last;
      end
      expected_pixels.push_back(r);
      pixels_accepted++;
    end
  end

  always @(posedge clk) begin : result_mon
    pixel_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        note_error("unexpected result", '0, pixel_out);
      end else begin
        want = expected_pixels.pop_front();
        if (pixel_out !== want.pixel) note_error("pixel_out", want.pixel, pixel_out);
        if (chunk_end !== want.is_last) note_error("chunk_end", 32'(want.is_last),
                                                   32'(chunk_end));
        results_checked++;
      end
    end
  end

  always @(negedge clk) out_ready <= ($urandom_range(99) >= out_idle_pct);

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_pixels.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    int chunk_goal;
    int cut_at;
    int sent_here;
    int w_val;
    int h_val;
    bit tall;

    model_cfg = '{width: WIDTH_RST, height: HEIGHT_RST, dir: DIR_FORWARD};
    left_px = '0;
    upleft_px = '0;
    col_cnt = 0;
    row_cnt = 0;

    directed_rows = '{
      stim_pass(32'hFFFFFFFF, 1'b0),            // reset size 64x64, forward
      stim_reg(REG_WIDTH, 32'd2),
      stim_reg(REG_HEIGHT, 32'd2),
      stim_pass(32'h00000000, 1'b0),
      stim_pass(32'h12345678, 1'b0),
      stim_px(32'h80808080),
      stim_reg(REG_DIR, 32'(DIR_BACK)),
      stim_reg(REG_WIDTH, 32'd3),
      stim_reg(REG_HEIGHT, 32'd3),
      stim_pass(32'h00000000, 1'b0),
      stim_pass(32'hFFFFFFFF, 1'b0),
      stim_pass(32'h7F80017E, 1'b0),
      stim_pass(32'h01020304, 1'b0),
      stim_px(32'hFFFFFFFF),
      stim_px(32'h00000000),
      stim_pass(32'hFEFEFEFE, 1'b0),
      stim_reg(REG_DIR, 32'(DIR_FORWARD)),      // direction flips mid-chunk
      stim_px(32'h55AA55AA),
      stim_px(32'h00FF00FF),
      stim_reg(REG_WIDTH, 32'd0),               // zero sizes act as 1x1
      stim_reg(REG_HEIGHT, 32'd0),
      stim_pass(32'hA5A5A5A5, 1'b1),
      stim_reg(REG_WIDTH, 32'd1),
      stim_reg(REG_HEIGHT, 32'd3),
      stim_pass(32'hFFFFFFFF, 1'b0),
      stim_pass(32'h01234567, 1'b0),
      stim_pass(32'hFFFFFFFF, 1'b1),
      stim_reg(REG_WIDTH, 32'd3),
      stim_reg(REG_HEIGHT, 32'd8191),           // saturates at the height limit
      stim_reg(REG_DIR, 32'(DIR_BACK)),
      stim_pass(32'h80000001, 1'b0),
      stim_pass(32'h7FFFFFFE, 1'b0),
      stim_pass(32'h00000000, 1'b0),
      stim_pass(32'h01010101, 1'b0),
      stim_px(32'hFF00FF00),
      stim_px(32'h00FF00FF),
      stim_reg(REG_HEIGHT, 32'd2),              // row count already past new height
      stim_pass(32'hFFFFFFFF, 1'b0),
      stim_px(32'h80808080),
      stim_px(32'h7F7F7F7F)
    };

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    check_reg(REG_WIDTH);
    check_reg(REG_HEIGHT);
    check_reg(REG_DIR);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_reg) begin
        wait_for_results();
        set_reg(directed_rows[i].reg_idx, directed_rows[i].value);
      end else begin
        typed_on = directed_rows[i].typed;
        typed_px = directed_rows[i].exp_pixel;
        typed_last = directed_rows[i].exp_last;
        send_pixel(directed_rows[i].value);
        typed_on = 1'b0;
      end
    end

    // one full-width row (width register above the limit), then a short
    // second row cut off by shrinking the width mid-chunk
    wait_for_results();
    set_reg(REG_WIDTH, 32'd2047);
    set_reg(REG_HEIGHT, 32'd2);
    set_reg(REG_DIR, 32'($urandom_range(1)));
    repeat (MAX_W + BIG_TAIL) send_pixel(random_pixel(last_pixel));
    wait_for_results();
    set_reg(REG_WIDTH, 32'(BIG_TAIL));
    send_pixel(random_pixel(last_pixel));

    while (pixels_accepted < PIXEL_TARGET) begin
      wait_for_results();
      case ($urandom_range(9))
        0:       w_val = 0;
        1:       w_val = 1;
        2:       w_val = 2;
        8:       w_val = $urandom_range(13, 48);
        9:       w_val = $urandom_range(1, 6);
        default: w_val = $urandom_range(3, 12);
      endcase
      tall = ($urandom_range(7) == 0);
      case ($urandom_range(9))
        0:       h_val = 0;
        1:       h_val = 1;
        9:       h_val = $urandom_range(7, 12);
        default: h_val = $urandom_range(2, 6);
      endcase
      if (tall) h_val = $urandom_range(1) ? HEIGHT_LIMIT : 8191;
      set_reg(REG_WIDTH, 32'(w_val));
      set_reg(REG_HEIGHT, 32'(h_val));
      set_reg(REG_DIR, 32'($urandom_range(1)));
      chunk_goal = chunks_predicted + $urandom_range(1, 3);
      if (tall)
        cut_at = $urandom_range(eff_width(), 4 * eff_width());
      else if ($urandom_range(3) == 0)
        cut_at = $urandom_range(0, eff_width() * eff_height() - 1);
      else
        cut_at = -1;
      sent_here = 0;
      while (chunks_predicted < chunk_goal) begin
        if (sent_here == cut_at) begin
          wait_for_results();
          if (tall) begin
            set_reg(REG_HEIGHT, 32'($urandom_range(0, 3)));
          end else begin
            case ($urandom_range(2))
              0: set_reg(REG_DIR, 32'(!model_cfg.dir));
              // growing the width past filled slots is only safe in the first row
              1: set_reg(REG_WIDTH, 32'(row_cnt == 0 ? $urandom_range(0, 12)
                                                     : $urandom_range(0, eff_width())));
              default: set_reg(REG_HEIGHT, 32'($urandom_range(0, 6)));
            endcase
          end
        end
        send_pixel(random_pixel(last_pixel));
        sent_here++;
      end
    end

    wait_for_results();
    repeat (8) @(posedge clk);
    if (expected_pixels.size() != 0)
      note_error("missing results", '0, 32'(expected_pixels.size()));
    $display("%0d pixels in %0d chunks checked, %0d register writes read back",
             results_checked, chunks_predicted, reg_writes);
    $display("covered both directions, mid-chunk changes, zero and saturated sizes");
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

### sim.f
design/pfc_pkg.sv
design/pfc_ram.sv
design/pfc_regs.sv
design/pfc_paeth.sv
design/paeth_filter_chunked.sv
test/testbench.sv
